### sv/glitch_safe_counter_extender_core_assert.svh
// Assertion macros for the counter extender RTL, included by gsce_out_buf.
`ifndef GLITCH_SAFE_COUNTER_EXTENDER_CORE_ASSERT_SVH
`define GLITCH_SAFE_COUNTER_EXTENDER_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
// Checked on clk_i and held off while rst_ni is low.
`define GSCE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked on clk_i at every edge, reset included.
`define GSCE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define GSCE_ASSERT(lbl, prop, msg)
`define GSCE_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

### sv/gsce_pkg.sv
// Shared types and constants of the counter extender.
`default_nettype none

package gsce_pkg;

  // Raw sample and extended count widths.
  localparam int unsigned SampleW = 32;
  localparam int unsigned CountW  = 64;

  // Low-part masks, upper-part increments and upper-part masks for the two counter widths.
  localparam logic [SampleW-1:0] Mask24 = 32'h00FF_FFFF;
  localparam logic [SampleW-1:0] Mask32 = 32'hFFFF_FFFF;
  localparam logic [CountW-1:0]  Step24 = 64'h0000_0000_0100_0000;
  localparam logic [CountW-1:0]  Step32 = 64'h0000_0001_0000_0000;
  localparam logic [CountW-1:0]  High24 = 64'hFFFF_FFFF_FF00_0000;
  localparam logic [CountW-1:0]  High32 = 64'hFFFF_FFFF_0000_0000;

  // Register select bit of paddr (byte address 4*index).
  localparam logic RegFullWidth = 1'b0;

  // One result word.
  typedef struct packed {
    logic [CountW-1:0] extended_count;
    logic              wrapped;
  } res_t;

  // Result push from the window stage to the output buffer.
  typedef struct packed {
    logic push;
    res_t res;
  } push_t;

endpackage

`default_nettype wire

### sv/glitch_safe_counter_extender_core.sv
// Counter extender: usage notes at the top of the file.
// Usage:
// - Input channel: one 32-bit raw counter read per word (raw_sample_i) under
//   in_valid_i / in_stall_o; a word is taken when valid is high and stall low.
// - Output channel: extended_count_o (64 bits) and wrapped_o under
//   out_valid_o / out_stall_i. A word is emitted only when the held window of
//   three samples is non-decreasing; the window then restarts empty.
// - Configuration: APB register 0 (byte address 0), bit 0 selects a 32-bit
//   counter when set and a 24-bit counter when clear. Write only while idle.
// - Throughput is one input word per cycle while in_stall_o is low; the window
//   compare and the 64-bit increment of the upper part sit between the input
//   register and the output buffer.
// - A result goes from the input register through the window compare and
//   the extension into the output buffer, which drives out_valid_o; the word
//   that completes the window waits in the input register while the buffer is full.
// - The two-entry output buffer absorbs a stall; in_stall_o rises only when
//   both entries are held and a word waits in the input register.
// - Reset clears the window, the last extended count and the mode (24-bit).
`default_nettype none

module glitch_safe_counter_extender_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [31:0] raw_sample_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic      [63:0] extended_count_o,
  output logic             wrapped_o
);

  logic            full_width;
  logic            buf_full;
  gsce_pkg::push_t push;
  gsce_pkg::res_t  res;

  // Configuration register.
  gsce_apb u_apb (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .full_width_o (full_width)
  );

  // Sample window and extension.
  gsce_window u_window (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .full_width_i (full_width),
    .in_valid_i   (in_valid_i),
    .raw_sample_i (raw_sample_i),
    .in_stall_o   (in_stall_o),
    .buf_full_i   (buf_full),
    .push_o       (push)
  );

  // Result buffer toward the receiver.
  gsce_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res)
  );

  assign extended_count_o = res.extended_count;
  assign wrapped_o        = res.wrapped;

endmodule

`default_nettype wire

### sv/gsce_apb.sv
// APB-style configuration register of the counter extender.
`default_nettype none

module gsce_apb (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output logic             full_width_o
);

  logic full_width_q;
  logic full_width_d;
  logic wr_en;

  assign pready = 1'b1;

  // A write completes in the access cycle; only bit 0 is kept.
  assign wr_en = psel && penable && pwrite && (paddr[2] == gsce_pkg::RegFullWidth);

  always_comb begin
    full_width_d = full_width_q;
    if (wr_en) begin
      full_width_d = pwdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_width_q <= 1'b0;
    end else begin
      full_width_q <= full_width_d;
    end
  end

  // Read back the register; unused addresses read as zero.
  always_comb begin
    prdata = 32'h0;
    if (paddr[2] == gsce_pkg::RegFullWidth) begin
      prdata = {31'h0, full_width_q};
    end
  end

  assign full_width_o = full_width_q;

endmodule

`default_nettype wire

### sv/gsce_window.sv
// Input register, three-sample window and 64-bit extension logic.
`default_nettype none

module gsce_window (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       full_width_i,
  input  wire logic                       in_valid_i,
  input  wire logic [gsce_pkg::SampleW-1:0] raw_sample_i,
  output logic                            in_stall_o,
  input  wire logic                       buf_full_i,
  output gsce_pkg::push_t                 push_o
);

  localparam logic [1:0] FillEmpty = 2'd0;
  localparam logic [1:0] FillOne   = 2'd1;
  localparam logic [1:0] FillTwo   = 2'd2;

  logic                          in_vld_q, in_vld_d;
  logic [gsce_pkg::SampleW-1:0]  in_smp_q;
  logic [gsce_pkg::SampleW-1:0]  older_q, older_d;
  logic [gsce_pkg::SampleW-1:0]  newer_q, newer_d;
  logic [1:0]                    fill_q, fill_d;
  logic [gsce_pkg::CountW-1:0]   last_q, last_d;

  logic                          load;
  logic                          adv;
  logic [gsce_pkg::SampleW-1:0]  mask;
  logic [gsce_pkg::SampleW-1:0]  a_m, b_m, c_m;
  logic                          mono;
  logic [gsce_pkg::CountW-1:0]   low;
  logic [gsce_pkg::CountW-1:0]   last_low;
  logic [gsce_pkg::CountW-1:0]   step;
  logic [gsce_pkg::CountW-1:0]   high;
  logic [gsce_pkg::CountW-1:0]   base;
  logic                          wrap;
  logic [gsce_pkg::CountW-1:0]   next_count;

  // Handshake: the input register stalls only while the output buffer is full.
  assign in_stall_o = in_vld_q && buf_full_i;
  assign load       = in_valid_i && !in_stall_o;
  assign adv        = in_vld_q && !buf_full_i;

  always_comb begin
    in_vld_d = in_vld_q;
    if (load) begin
      in_vld_d = 1'b1;
    end else if (adv) begin
      in_vld_d = 1'b0;
    end
  end

  // Masked window compare for the current counter width.
  assign mask = full_width_i ? gsce_pkg::Mask32 : gsce_pkg::Mask24;
  assign a_m  = older_q & mask;
  assign b_m  = newer_q & mask;
  assign c_m  = in_smp_q & mask;
  assign mono = (a_m <= b_m) && (b_m <= c_m);

  // Extension of the middle sample against the last emitted count.
  assign low        = {32'h0, b_m};
  assign last_low   = last_q & {32'h0, mask};
  assign step       = full_width_i ? gsce_pkg::Step32 : gsce_pkg::Step24;
  assign high       = full_width_i ? gsce_pkg::High32 : gsce_pkg::High24;
  assign wrap       = low < last_low;
  assign base       = wrap ? (last_q + step) : last_q;
  assign next_count = (base & high) | low;

  // Window update and result push for the word in the input register.
  always_comb begin
    older_d      = older_q;
    newer_d      = newer_q;
    fill_d       = fill_q;
    last_d       = last_q;
    push_o.push  = 1'b0;
    push_o.res.extended_count = next_count;
    push_o.res.wrapped        = wrap;
    if (adv) begin
      case (fill_q)
        FillEmpty: begin
          older_d = in_smp_q;
          fill_d  = FillOne;
        end
        FillOne: begin
          newer_d = in_smp_q;
          fill_d  = FillTwo;
        end
        default: begin
          if (mono) begin
            push_o.push = 1'b1;
            last_d      = next_count;
            fill_d      = FillEmpty;
          end else begin
            older_d = newer_q;
            newer_d = in_smp_q;
            fill_d  = FillTwo;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      older_q  <= '0;
      newer_q  <= '0;
      fill_q   <= FillEmpty;
      last_q   <= '0;
    end else begin
      in_vld_q <= in_vld_d;
      older_q  <= older_d;
      newer_q  <= newer_d;
      fill_q   <= fill_d;
      last_q   <= last_d;
    end
  end

  // Sample payload register.
  always_ff @(posedge clk_i) begin
    if (load) begin
      in_smp_q <= raw_sample_i;
    end
  end

endmodule

`default_nettype wire

### sv/gsce_out_buf.sv
// Two-entry output buffer (result register plus skid entry).
`default_nettype none

`include "glitch_safe_counter_extender_core_assert.svh"

module gsce_out_buf (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire gsce_pkg::push_t push_i,
  output logic                 full_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output gsce_pkg::res_t       res_o
);

  logic [1:0]      cnt_q, cnt_d;
  gsce_pkg::res_t  ent_q [2];
  gsce_pkg::res_t  ent_d [2];
  logic            pop;
  logic [1:0]      cnt_pop;

  assign out_valid_o = (cnt_q != 2'd0);
  assign full_o      = (cnt_q == 2'd2);
  assign pop         = out_valid_o && !out_stall_i;
  assign res_o       = ent_q[0];

  // Pop shifts the skid entry forward; a push lands behind what remains.
  always_comb begin
    ent_d[0] = ent_q[0];
    ent_d[1] = ent_q[1];
    cnt_pop  = cnt_q;
    if (pop) begin
      ent_d[0] = ent_q[1];
      cnt_pop  = cnt_q - 2'd1;
    end
    cnt_d = cnt_pop;
    if (push_i.push) begin
      if (cnt_pop == 2'd0) begin
        ent_d[0] = push_i.res;
      end else begin
        ent_d[1] = push_i.res;
      end
      cnt_d = cnt_pop + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Result words carry no reset.
  always_ff @(posedge clk_i) begin
    ent_q[0] <= ent_d[0];
    ent_q[1] <= ent_d[1];
  end

  // A push never arrives while both entries are held.
  `GSCE_ASSERT(a_no_push_when_full, push_i.push |-> (cnt_q != 2'd2),
               "result pushed into a full output buffer")
  // A full buffer under stall keeps both words.
  `GSCE_ASSERT(a_full_holds, (full_o && out_stall_i) |=> full_o,
               "full output buffer lost a word while stalled")
  // A pop without a push lowers the count by one.
  `GSCE_ASSERT(a_pop_count, (pop && !push_i.push) |=> (cnt_q == $past(cnt_q) - 2'd1),
               "output buffer count wrong after pop")

endmodule

`default_nettype wire

### tb/sv/glitch_safe_counter_extender_core_checker.sv
// Channel monitor, count extension predictor and result comparator for the counter extender.
`timescale 1ns / 100ps

module glitch_safe_counter_extender_core_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        in_valid_i,
  input  logic        in_stall_o,
  input  logic [31:0] raw_sample_i,
  input  logic        out_valid_o,
  input  logic        out_stall_i,
  input  logic [63:0] extended_count_o,
  input  logic        wrapped_o,
  output int          err_count_o,
  output int          pending_o
);

  // Register index of the counter width select.
  localparam int unsigned RegIdxFullWidth = 0;

  // Mirror of the block's mode, sample window and last extended count.
  logic           full_width;
  logic [31:0]    window_old;
  logic [31:0]    window_mid;
  logic [1:0]     window_fill;
  logic [63:0]    last_count;
  gsce_pkg::res_t count_q[$];
  int             mismatches = 0;

  // Extends a trusted sample to 64 bits and queues the expected word.
  function automatic void extend_sample(input logic [31:0] sample);
    logic [63:0]    low_mask;
    logic [63:0]    step;
    logic [63:0]    high;
    logic [63:0]    low;
    gsce_pkg::res_t word;
    low_mask = full_width ? {32'h0, gsce_pkg::Mask32} : {32'h0, gsce_pkg::Mask24};
    step     = full_width ? gsce_pkg::Step32 : gsce_pkg::Step24;
    high     = full_width ? gsce_pkg::High32 : gsce_pkg::High24;
    low      = {32'h0, sample} & low_mask;
    if (low < (last_count & low_mask)) begin
      word.extended_count = ((last_count + step) & high) | low;
      word.wrapped        = 1'b1;
    end else begin
      word.extended_count = (last_count & high) | low;
      word.wrapped        = 1'b0;
    end
    last_count = word.extended_count;
    count_q.push_back(word);
  endfunction

  // Advances the three-sample window by one raw sample.
  function automatic void take_sample(input logic [31:0] raw);
    logic [31:0] mask;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    mask = full_width ? gsce_pkg::Mask32 : gsce_pkg::Mask24;
    case (window_fill)
      2'd0: begin
        window_old  = raw;
        window_fill = 2'd1;
      end
      2'd1: begin
        window_mid  = raw;
        window_fill = 2'd2;
      end
      default: begin
        a = window_old & mask;
        b = window_mid & mask;
        c = raw & mask;
        if (a <= b && b <= c) begin
          extend_sample(window_mid);
          window_fill = 2'd0;
        end else begin
          window_old  = window_mid;
          window_mid  = raw;
          window_fill = 2'd2;
        end
      end
    endcase
  endfunction

  // Watch the register port and both channels at every rising edge.
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    gsce_pkg::res_t want;
    if (!rst_ni) begin
      full_width  = 1'b0;
      window_old  = '0;
      window_mid  = '0;
      window_fill = '0;
      last_count  = '0;
      count_q.delete();
      pending_o   <= 0;
    end else begin
      // Register writes; only index 0 holds state and only bit 0 of it.
      if (psel && penable && pwrite && pready && (paddr >> 2) == RegIdxFullWidth) begin
        full_width = pwdata[0];
      end

      // Accepted result word against the oldest expectation.
      if (out_valid_o && !out_stall_i) begin
        if (count_q.size() == 0) begin
          $error("unexpected word: extended_count %h wrapped %b", extended_count_o, wrapped_o);
          mismatches++;
        end else begin
          want = count_q.pop_front();
          if (extended_count_o !== want.extended_count) begin
            $error("extended_count: expected %h, got %h", want.extended_count,
                   extended_count_o);
            mismatches++;
          end
          if (wrapped_o !== want.wrapped) begin
            $error("wrapped: expected %b, got %b", want.wrapped, wrapped_o);
            mismatches++;
          end
        end
      end

      // Accepted sample word into the predicted window.
      if (in_valid_i && !in_stall_o) begin
        take_sample(raw_sample_i);
      end

      pending_o <= count_q.size();
    end
    err_count_o <= mismatches;
  end

endmodule

### tb/sv/glitch_safe_counter_extender_core_tb.sv
// Stimulus, clock, reset and verdict for the glitch-safe counter extender.
`timescale 1ns / 100ps

module glitch_safe_counter_extender_core_tb;

  localparam int         CycleLimit    = 500000;
  localparam int         SettleCycles  = 6;
  localparam int         ResetCycles   = 12;
  localparam int         PhaseCount    = 8;
  localparam int         PhaseItems    = 116;
  localparam int         MaxGap        = 16;
  localparam logic [2:0] AddrFullWidth = 3'd0;
  localparam logic [2:0] AddrUnused    = 3'd4;
  // Counter width chosen for each random phase, one bit per phase.
  localparam logic [PhaseCount-1:0] PhaseModes = 8'b0110_0101;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        psel         = 1'b0;
  logic        penable      = 1'b0;
  logic        pwrite       = 1'b0;
  logic [2:0]  paddr        = '0;
  logic [31:0] pwdata       = '0;
  logic        in_valid_i   = 1'b0;
  logic [31:0] raw_sample_i = '0;
  logic        out_stall_i  = 1'b0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [63:0] extended_count_o;
  logic        wrapped_o;

  int          cycle_count = 0;
  int          in_gap_max  = MaxGap;
  int          out_gap_max = MaxGap;
  logic        full_mode   = 1'b0;
  logic [31:0] counter_now = '0;
  int          err_count;
  int          pending;

  // 4 ns clock.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  glitch_safe_counter_extender_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .raw_sample_i    (raw_sample_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .extended_count_o(extended_count_o),
    .wrapped_o       (wrapped_o)
  );

  glitch_safe_counter_extender_core_checker u_extender_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .pready          (pready),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .raw_sample_i    (raw_sample_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .extended_count_o(extended_count_o),
    .wrapped_o       (wrapped_o),
    .err_count_o     (err_count),
    .pending_o       (pending)
  );

  // Run guard: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("glitch_safe_counter_extender_core_tb: errors");
      $finish;
    end
  end

  // Stops sending and waits until every expected word has come out; samples may remain in the window.
  task automatic wait_quiet();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Register write with setup and access cycles, only once the block is idle.
  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    wait_quiet();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == AddrFullWidth) full_mode = data[0];
  endtask

  // Offers one sample word after a random gap and holds it until taken.
  task automatic send_sample(input logic [31:0] value);
    int gap;
    gap = (in_gap_max == 0 || $urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    raw_sample_i <= value;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Next read of a mostly advancing counter, with latch glitches and wraps mixed in.
  function automatic logic [31:0] next_raw_sample();
    int          pick;
    logic [31:0] value;
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      value = $urandom;
    end else if (pick < 9) begin
      value = counter_now ^ (32'h1 << $urandom_range(0, 31));
    end else begin
      if (pick < 13) begin
        counter_now = 32'hFFFF_FFFF - $urandom_range(0, 6);
      end else if (pick < 17) begin
        counter_now = counter_now + $urandom_range(0, 32'h000F_FFFF);
      end else begin
        counter_now = counter_now + $urandom_range(0, 3);
      end
      value = counter_now;
      // The upper byte is noise in 24-bit mode.
      if (!full_mode) value[31:24] = 8'($urandom_range(0, 255));
    end
    return value;
  endfunction

  // Output side stalls for a random number of cycles before each word.
  initial begin : result_stall
    int hold;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      hold = (out_gap_max == 0 || $urandom_range(0, 1) == 0) ? 0 :
             $urandom_range(0, out_gap_max);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  // Reset, directed cases, random phases and the verdict.
  initial begin : stimulus
    int          p;
    int          k;
    logic [31:0] word;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    // 24-bit mode; the write to the unused index must change nothing.
    write_reg(AddrFullWidth, 32'h0);
    write_reg(AddrUnused, 32'hFFFF_FFFF);
    // All-zero window, all-ones window masked to 24 bits, then a wrap.
    send_sample(32'h0);
    send_sample(32'h0);
    send_sample(32'h0);
    send_sample(32'hFFFF_FFFF);
    send_sample(32'hFFFF_FFFF);
    send_sample(32'hFFFF_FFFF);
    send_sample(32'h5);
    send_sample(32'h6);
    send_sample(32'h7);
    // A falling pair slides the window before it settles.
    send_sample(32'hA);
    send_sample(32'h3);
    send_sample(32'h4);
    send_sample(32'h5);
    // Upper byte differs but the low 24 bits rise.
    send_sample(32'hAB00_0010);
    send_sample(32'h0100_0011);
    send_sample(32'hFF00_0012);

    // 32-bit mode: top of range, then a wrap of the low word.
    write_reg(AddrFullWidth, 32'hFFFF_FFFF);
    send_sample(32'hFFFF_FFFE);
    send_sample(32'hFFFF_FFFF);
    send_sample(32'hFFFF_FFFF);
    send_sample(32'h1);
    send_sample(32'h2);
    send_sample(32'h3);
    // Held samples fall in 32 bits, rise once the mode drops to 24 bits.
    send_sample(32'h0200_0005);
    send_sample(32'h0100_0006);
    write_reg(AddrFullWidth, 32'hFFFF_FFFE);
    send_sample(32'h0000_0007);

    // Random phases: mode, idling and back-pressure vary per phase.
    for (p = 0; p < PhaseCount; p++) begin
      in_gap_max  = (p == 2 || p == 5) ? 0 : MaxGap;
      out_gap_max = (p == 2 || p == 6) ? 0 : MaxGap;
      word        = $urandom;
      word[0]     = PhaseModes[p];
      write_reg(AddrFullWidth, word);
      counter_now = $urandom;
      for (k = 0; k < PhaseItems; k++) begin
        send_sample(next_raw_sample());
      end
    end

    wait_quiet();
    if (err_count == 0 && pending == 0) begin
      $display("glitch_safe_counter_extender_core_tb: clean");
    end else begin
      $display("glitch_safe_counter_extender_core_tb: errors");
    end
    $finish;
  end

endmodule
